@@ design/rigf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigf_pkg: RS485 idle-gap framer definitions
// Operation codes, field widths and reset values shared by the framer files.
// ----------------------------------------------------------------------------
package rigf_pkg;

	localparam int unsigned BUFFER_DEPTH_DEFAULT = 128;
	localparam logic [7:0]  IDLE_TICKS_RESET     = 8'd50;

	localparam int unsigned OP_W     = 3;
	localparam int unsigned INDEX_W  = 7;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 8;
	localparam int unsigned TIMER_W  = 8;
	localparam int unsigned S_DATA_W = 24;
	localparam int unsigned M_DATA_W = 32;
	localparam int unsigned INDEX_N  = 2 ** INDEX_W;

	typedef enum logic [OP_W-1:0] {
		OP_RX_BYTE  = 3'd0,
		OP_TX_DONE  = 3'd1,
		OP_TICK     = 3'd2,
		OP_LOAD_TX  = 3'd3,
		OP_START_TX = 3'd4,
		OP_READ_RX  = 3'd5,
		OP_RELEASE  = 3'd6
	} op_t;

endpackage

@@ design/rigf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigf_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
module rigf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/rs485_idle_gap_framer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485_idle_gap_framer_unit: half-duplex RS485 buffer engine
// Receive buffer with idle-gap framing, transmit buffer with driver enable.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake         | Payload
// s_*     | in        | s_tvalid/s_tready | s_tuser op, s_tdata index/byte/len
// m_*     | out       | m_tvalid/m_tready | m_tuser tx_valid, m_tdata status
// cfg_*   | in        | cfg_valid/ready   | cfg_data idle_ticks
//
// One beat per cycle unless m_tready stalls; m_tvalid comes from stage 2.
// State updates in the accept cycle; buffer read data is registered in the RAM.
// Two-stage pipeline: with m_tready low, input stalls once both stages hold a beat.
// arst_n clears control state; buffers are uninitialised, no clearing pass.
// ----------------------------------------------------------------------------
module rs485_idle_gap_framer_unit
	import rigf_pkg::*;
#(
	parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // entry_index, data_byte, send_length, pad
	input  logic [OP_W-1:0]     s_tuser,   // op
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // tx_byte, driver_enable, frame_ready,
	                                       // rx_length, read_data, pad
	output logic [0:0]          m_tuser,   // tx_valid
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [TIMER_W-1:0]  cfg_data
);

	localparam int unsigned AW = $clog2(BUFFER_DEPTH);
	localparam int unsigned FW = $clog2(BUFFER_DEPTH + 1);
	localparam int unsigned CW = (FW > LEN_W) ? FW : LEN_W;
	localparam logic [FW-1:0] DEPTH_F = FW'(BUFFER_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
	localparam logic [AW-1:0] LAST_POS = AW'(BUFFER_DEPTH - 1);

	// entry index taken modulo the buffer depth
	logic [AW-1:0] idx_lut [INDEX_N];
	for (genvar g = 0; g < INDEX_N; g++) begin : g_idx
		assign idx_lut[g] = AW'(g % BUFFER_DEPTH);
	end

	op_t                op;
	logic [INDEX_W-1:0] entry_index;
	logic [BYTE_W-1:0]  data_byte;
	logic [LEN_W-1:0]   send_length;
	logic [AW-1:0]      idx;

	logic               acc;
	logic               adv;

	logic [TIMER_W-1:0] idle_ticks_q;
	logic [FW-1:0]      rx_fill_q,    rx_fill_n;
	logic [TIMER_W-1:0] idle_timer_q, idle_timer_n;
	logic               frame_done_q, frame_done_n;
	logic [FW-1:0]      tx_rem_q,     tx_rem_n;
	logic [AW-1:0]      tx_pos_q,     tx_pos_n;
	logic               drive_on_q,   drive_on_n;

	logic [AW-1:0]      rx_waddr;
	logic               rx_we;
	logic               tx_we;
	logic [AW-1:0]      tx_raddr;
	logic               emit;
	logic               rd_sel;
	logic [AW-1:0]      pos_inc;
	logic [CW-1:0]      len_w;
	logic [FW-1:0]      len_c;

	logic [BYTE_W-1:0]  rx_rdata;
	logic [BYTE_W-1:0]  tx_rdata;

	logic               v_s1;
	logic               tx_valid_s1;
	logic               rd_sel_s1;
	logic               drive_s1;
	logic               frame_s1;
	logic [7:0]         rx_len_s1;

	logic               v_s2;
	logic               tx_valid_s2;
	logic [BYTE_W-1:0]  tx_byte_s2;
	logic               drive_s2;
	logic               frame_s2;
	logic [7:0]         rx_len_s2;
	logic [BYTE_W-1:0]  read_data_s2;

	assign op          = op_t'(s_tuser);
	assign entry_index = s_tdata[INDEX_W-1:0];
	assign data_byte   = s_tdata[INDEX_W+BYTE_W-1:INDEX_W];
	assign send_length = s_tdata[INDEX_W+BYTE_W+LEN_W-1:INDEX_W+BYTE_W];
	assign idx         = idx_lut[entry_index];

	assign adv      = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || adv;
	assign acc      = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// full buffer wraps the next stored byte to position 0
	assign rx_waddr = (rx_fill_q >= DEPTH_F) ? '0 : rx_fill_q[AW-1:0];
	assign pos_inc  = (tx_pos_q == LAST_POS) ? '0 : tx_pos_q + AW'(1);
	assign len_w    = CW'(send_length);
	assign len_c    = FW'((len_w > DEPTH_C) ? DEPTH_C : len_w);

	always_comb begin
		rx_fill_n    = rx_fill_q;
		idle_timer_n = idle_timer_q;
		frame_done_n = frame_done_q;
		tx_rem_n     = tx_rem_q;
		tx_pos_n     = tx_pos_q;
		drive_on_n   = drive_on_q;
		rx_we        = 1'b0;
		tx_we        = 1'b0;
		tx_raddr     = tx_pos_q;
		emit         = 1'b0;
		rd_sel       = 1'b0;
		case (op)
			OP_RX_BYTE: begin
				if (!frame_done_q) begin
					rx_we     = 1'b1;
					rx_fill_n = FW'(rx_waddr) + FW'(1);
				end
				idle_timer_n = idle_ticks_q;
			end
			OP_TX_DONE: begin
				if (tx_rem_q != '0) begin
					emit     = 1'b1;
					tx_pos_n = pos_inc;
					tx_rem_n = tx_rem_q - FW'(1);
				end else begin
					tx_pos_n   = '0;
					drive_on_n = 1'b0;
				end
			end
			OP_TICK: begin
				if (idle_timer_q != '0) begin
					idle_timer_n = idle_timer_q - TIMER_W'(1);
					if (idle_timer_q == TIMER_W'(1) && rx_fill_q != '0) begin
						frame_done_n = 1'b1;
					end
				end
			end
			OP_LOAD_TX: begin
				tx_we = 1'b1;
			end
			OP_START_TX: begin
				// a new start with a nonzero length abandons any running send
				if (len_c != '0) begin
					emit       = 1'b1;
					drive_on_n = 1'b1;
					tx_raddr   = '0;
					tx_pos_n   = AW'(1);
					tx_rem_n   = len_c - FW'(1);
				end
			end
			OP_READ_RX: begin
				rd_sel = 1'b1;
			end
			OP_RELEASE: begin
				frame_done_n = 1'b0;
				rx_fill_n    = '0;
			end
			default: begin
			end
		endcase
	end

	rigf_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUFFER_DEPTH)
	) u_rx_ram (
		.clk  (clk),
		.we   (acc && rx_we),
		.waddr(rx_waddr),
		.wdata(data_byte),
		.re   (acc),
		.raddr(idx),
		.rdata(rx_rdata)
	);

	rigf_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUFFER_DEPTH)
	) u_tx_ram (
		.clk  (clk),
		.we   (acc && tx_we),
		.waddr(idx),
		.wdata(data_byte),
		.re   (acc),
		.raddr(tx_raddr),
		.rdata(tx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_ticks_q <= IDLE_TICKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			idle_ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_fill_q    <= '0;
			idle_timer_q <= '0;
			frame_done_q <= 1'b0;
			tx_rem_q     <= '0;
			tx_pos_q     <= '0;
			drive_on_q   <= 1'b0;
		end else if (acc) begin
			rx_fill_q    <= rx_fill_n;
			idle_timer_q <= idle_timer_n;
			frame_done_q <= frame_done_n;
			tx_rem_q     <= tx_rem_n;
			tx_pos_q     <= tx_pos_n;
			drive_on_q   <= drive_on_n;
		end
	end

	// stage 1: beat accepted, buffer reads in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			tx_valid_s1 <= emit;
			rd_sel_s1   <= rd_sel;
			drive_s1    <= drive_on_n;
			frame_s1    <= frame_done_n;
			rx_len_s1   <= 8'(rx_fill_n);
		end
	end

	// stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (m_tready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tx_valid_s2  <= tx_valid_s1;
			tx_byte_s2   <= tx_valid_s1 ? tx_rdata : '0;
			drive_s2     <= drive_s1;
			frame_s2     <= frame_s1;
			rx_len_s2    <= rx_len_s1;
			read_data_s2 <= rd_sel_s1 ? rx_rdata : '0;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tuser  = tx_valid_s2;
	assign m_tdata  = {6'd0, read_data_s2, rx_len_s2, frame_s2, drive_s2, tx_byte_s2};

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fill_q <= DEPTH_F)
		else $error("receive count beyond buffer depth");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tx_pos_q <= LAST_POS)
		else $error("transmit position beyond buffer");

	a_frame_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done_q |-> rx_fill_q != '0)
		else $error("frame complete with empty buffer");

	a_send_drives: assert property (@(posedge clk) disable iff (!arst_n)
		tx_rem_q != '0 |-> drive_on_q)
		else $error("bytes pending with driver off");

	a_tx_beat_drives: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[8])
		else $error("byte sent with driver off");
`endif

endmodule

@@ dv/tb_rs485_idle_gap_framer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rs485_idle_gap_framer_unit: self-checking bench for the RS485 framer
// Drives op beats on the slave stream, predicts each status beat with an
// in-bench copy of the buffer and timer state, and compares every master
// beat field by field. A short directed table comes first, then phases of
// random receive frames, transmit sends and noise under different
// idle_ticks settings and idling patterns, one phase with a long back-off.
// ----------------------------------------------------------------------------
module tb_rs485_idle_gap_framer_unit;
	import rigf_pkg::*;

	localparam int DEPTH        = BUFFER_DEPTH_DEFAULT;
	localparam int DRAIN_PAD    = 4;
	localparam int HOLD_CYCLES  = 150;
	localparam int STALL_LIMIT  = 4000;
	localparam int SHOW_MAX     = 10;
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       driver_enable;
		logic       frame_ready;
		logic [7:0] rx_length;
		logic [7:0] read_data;
	} framer_status_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [6:0]      idx;
		logic [7:0]      data;
		logic [7:0]      len;
		logic            fixed;
		framer_status_t  want;
	} stim_row_t;

	localparam framer_status_t ALL_ZERO = '0;
	localparam framer_status_t ONE_HELD = '{1'b0, 8'h00, 1'b0, 1'b0, 8'd1, 8'h00};

	// fixed rows carry an expectation written in the table, used in place of the prediction
	localparam stim_row_t DIRECTED_ROWS [26] = '{
		'{OP_TICK,     7'h00, 8'h00, 8'h00, 1'b1, ALL_ZERO},
		'{OP_UNUSED,   7'h7f, 8'hff, 8'hff, 1'b1, ALL_ZERO},
		'{OP_RX_BYTE,  7'h7f, 8'hff, 8'hff, 1'b1, ONE_HELD},
		'{OP_RX_BYTE,  7'h00, 8'h00, 8'h00, 1'b0, ALL_ZERO},
		'{OP_READ_RX,  7'h00, 8'h00, 8'h00, 1'b0, ALL_ZERO},
		'{OP_TICK,     7'h55, 8'h55, 8'h55, 1'b0, ALL_ZERO},
		'{OP_TICK,     7'h2a, 8'haa, 8'haa, 1'b0, ALL_ZERO},
		'{OP_RX_BYTE,  7'h2a, 8'ha5, 8'h80, 1'b0, ALL_ZERO},
		'{OP_TICK,     7'h00, 8'h00, 8'h00, 1'b0, ALL_ZERO},
		'{OP_TICK,     7'h00, 8'h00, 8'h00, 1'b0, ALL_ZERO},
		'{OP_RELEASE,  7'h7f, 8'hff, 8'hff, 1'b1, ALL_ZERO},
		'{OP_RX_BYTE,  7'h00, 8'h3c, 8'h00, 1'b0, ALL_ZERO},
		'{OP_RELEASE,  7'h00, 8'h00, 8'h00, 1'b1, ALL_ZERO},
		'{OP_TICK,     7'h00, 8'h00, 8'h00, 1'b0, ALL_ZERO},
		'{OP_TICK,     7'h00, 8'h00, 8'h00, 1'b0, ALL_ZERO},
		'{OP_LOAD_TX,  7'h00, 8'h00, 8'h00, 1'b0, ALL_ZERO},
		'{OP_LOAD_TX,  7'h01, 8'hff, 8'h00, 1'b0, ALL_ZERO},
		'{OP_LOAD_TX,  7'h7f, 8'h81, 8'h00, 1'b0, ALL_ZERO},
		'{OP_TX_DONE,  7'h00, 8'h00, 8'h00, 1'b1, ALL_ZERO},
		'{OP_START_TX, 7'h00, 8'h00, 8'h00, 1'b1, ALL_ZERO},
		'{OP_START_TX, 7'h00, 8'h00, 8'h02, 1'b0, ALL_ZERO},
		'{OP_TX_DONE,  7'h00, 8'h00, 8'h00, 1'b0, ALL_ZERO},
		'{OP_TX_DONE,  7'h00, 8'h00, 8'h00, 1'b0, ALL_ZERO},
		'{OP_START_TX, 7'h00, 8'h00, 8'h02, 1'b0, ALL_ZERO},
		'{OP_START_TX, 7'h00, 8'h00, 8'h01, 1'b0, ALL_ZERO},
		'{OP_TX_DONE,  7'h00, 8'h00, 8'h00, 1'b0, ALL_ZERO}
	};

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;
	logic [OP_W-1:0]     s_tuser  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [0:0]          m_tuser;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [TIMER_W-1:0]  cfg_data  = '0;

	// predicted framer state
	logic [7:0] rx_mem [DEPTH];
	logic [7:0] tx_mem [DEPTH];
	bit         tx_seen [DEPTH];
	logic [7:0] rx_count   = '0;
	logic [7:0] gap_timer  = '0;
	logic       frame_held = 1'b0;
	logic [7:0] tx_left    = '0;
	logic [6:0] tx_ptr     = '0;
	logic       de_on      = 1'b0;
	logic [7:0] idle_cfg   = IDLE_TICKS_RESET;
	int         rx_reach   = 0;

	framer_status_t pending_status [$];
	bit             beat_fixed = 1'b0;
	framer_status_t beat_fixed_status = '0;

	int fail_count    = 0;
	int beats_sent    = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_asks     = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;
	bit went_long     = 1'b0;

	rs485_idle_gap_framer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // entry_index, data_byte, send_length, pad
		.s_tuser   (s_tuser),   // op
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // tx_byte, driver_enable, frame_ready, rx_length,
		                        // read_data, pad
		.m_tuser   (m_tuser),   // tx_valid
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] tx_take();
		logic [7:0] b;
		b = tx_mem[tx_ptr];
		tx_ptr = tx_ptr + 1'b1;   // 7-bit pointer wraps at the depth
		tx_left = tx_left - 1'b1;
		return b;
	endfunction

	function automatic framer_status_t framer_step(logic [OP_W-1:0] op, logic [6:0] idx,
			logic [7:0] data, logic [7:0] len);
		framer_status_t r;
		logic [7:0] n;
		r = '0;
		n = len;
		case (op)
			OP_RX_BYTE: begin
				if (!frame_held) begin
					if (rx_count >= 8'(DEPTH))
						rx_count = '0;
					rx_mem[rx_count[6:0]] = data;
					rx_count = rx_count + 1'b1;
					if (int'(rx_count) > rx_reach)
						rx_reach = int'(rx_count);
				end
				gap_timer = idle_cfg;
			end
			OP_TX_DONE: begin
				if (tx_left != 0) begin
					r.tx_valid = 1'b1;
					r.tx_byte  = tx_take();
				end else begin
					tx_ptr = '0;
					de_on  = 1'b0;
				end
			end
			OP_TICK: begin
				if (gap_timer != 0) begin
					gap_timer = gap_timer - 1'b1;
					if (gap_timer == 0 && rx_count != 0)
						frame_held = 1'b1;
				end
			end
			OP_LOAD_TX: begin
				tx_mem[idx]  = data;
				tx_seen[idx] = 1'b1;
			end
			OP_START_TX: begin
				if (n > 8'(DEPTH))
					n = 8'(DEPTH);
				if (n != 0) begin
					de_on      = 1'b1;
					tx_ptr     = '0;
					tx_left    = n;
					r.tx_valid = 1'b1;
					r.tx_byte  = tx_take();
				end
			end
			OP_READ_RX: r.read_data = rx_mem[idx];
			OP_RELEASE: begin
				frame_held = 1'b0;
				rx_count   = '0;
			end
			default: ;
		endcase
		r.driver_enable = de_on;
		r.frame_ready   = frame_held;
		r.rx_length     = rx_count;
		return r;
	endfunction

	function automatic int tx_prefix();
		int p;
		p = 0;
		while (p < DEPTH && tx_seen[p])
			p++;
		return p;
	endfunction

	task automatic note_fail(string what, logic [7:0] want, logic [7:0] got);
		fail_count++;
		if (fail_count <= SHOW_MAX)
			$display("%0t mismatch %s: expected %0h, got %0h", $time, what, want, got);
	endtask

	always @(posedge clk) begin
		framer_status_t want;
		framer_status_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				idle_cfg = cfg_data;
			if (s_tvalid && s_tready) begin
				want = framer_step(s_tuser, s_tdata[6:0], s_tdata[14:7], s_tdata[22:15]);
				if (beat_fixed)
					want = beat_fixed_status;
				pending_status.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got = '{m_tuser[0], m_tdata[7:0], m_tdata[8], m_tdata[9], m_tdata[17:10],
					m_tdata[25:18]};
				if (pending_status.size() == 0) begin
					fail_count++;
					if (fail_count <= SHOW_MAX)
						$display("%0t status beat with nothing expected: %h", $time, got);
				end else begin
					want = pending_status.pop_front();
					if (got.tx_valid !== want.tx_valid)
						note_fail("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
					if (got.tx_byte !== want.tx_byte)
						note_fail("tx_byte", want.tx_byte, got.tx_byte);
					if (got.driver_enable !== want.driver_enable)
						note_fail("driver_enable", 8'(want.driver_enable), 8'(got.driver_enable));
					if (got.frame_ready !== want.frame_ready)
						note_fail("frame_ready", 8'(want.frame_ready), 8'(got.frame_ready));
					if (got.rx_length !== want.rx_length)
						note_fail("rx_length", want.rx_length, got.rx_length);
					if (got.read_data !== want.read_data)
						note_fail("read_data", want.read_data, got.read_data);
				end
			end
		end
	end

	// receiver: random stalls, plus a long back-off on request
	always @(negedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", quiet_cycles);
			$display("FAIL");
			$finish;
		end
	end

	// one op beat; keeps reads inside the written part of the receive buffer and
	// sends inside the loaded part of the transmit buffer
	task automatic put_beat(logic [OP_W-1:0] op, logic [6:0] idx, logic [7:0] data,
			logic [7:0] len, logic fixed = 1'b0, framer_status_t want = '0);
		int p;
		int gap;
		p = tx_prefix();
		gap = 0;
		if (op == OP_READ_RX) begin
			if (rx_reach == 0)
				op = OP_TICK;
			else if (int'(idx) >= rx_reach)
				idx = 7'($urandom_range(rx_reach - 1, 0));
		end
		if (op == OP_START_TX && p < DEPTH && int'(len) > p)
			len = (p == 0) ? 8'd0 : 8'($urandom_range(p, 1));
		while (gap < 50 && $urandom_range(99, 0) < send_idle_pct)
			gap++;
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		beat_fixed        = fixed;
		beat_fixed_status = want;
		s_tuser  <= op;
		s_tdata  <= {1'b0, len, data, idx};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic put_random(logic [OP_W-1:0] op);
		put_beat(op, 7'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_status.size() != 0)
			@(negedge clk);
		repeat (DRAIN_PAD) @(negedge clk);
	endtask

	task automatic write_idle_ticks(logic [7:0] v);
		wait_drained();
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(logic [7:0] ticks, int send_pct, int stall, int budget, bit squeeze);
		int first;
		int n;
		int p;
		int pick;
		write_idle_ticks(ticks);
		send_idle_pct = send_pct;
		stall_pct <= stall;
		if (squeeze)
			hold_asks <= hold_asks + 1;
		first = beats_sent;
		while (beats_sent - first < budget) begin
			pick = $urandom_range(9, 0);
			if (pick <= 3) begin
				// receive frame: bytes, idle gap, a few reads, usually a release
				if (!went_long || $urandom_range(7, 0) == 0) begin
					n = $urandom_range(140, 120);
					went_long = 1'b1;
				end else begin
					n = $urandom_range(12, 1);
				end
				repeat (n) begin
					put_random(OP_RX_BYTE);
					if ($urandom_range(5, 0) == 0)
						put_random(OP_TICK);
				end
				repeat (int'(gap_timer) + $urandom_range(2, 0))
					put_random(OP_TICK);
				repeat ($urandom_range(3, 0))
					put_random(OP_READ_RX);
				if ($urandom_range(4, 0) != 0)
					put_random(OP_RELEASE);
			end else if (pick <= 6) begin
				// send: extend the loaded area, start, then mostly transmit-done (with occasional loads and restarts) until idle
				repeat ($urandom_range(16, 1)) begin
					p = tx_prefix();
					put_beat(OP_LOAD_TX, (p < DEPTH) ? 7'(p) : 7'($urandom), 8'($urandom),
						8'($urandom));
				end
				p = tx_prefix();
				if (p == DEPTH && $urandom_range(3, 0) == 0)
					n = $urandom_range(255, 129);
				else
					n = $urandom_range(p, 1);
				put_beat(OP_START_TX, 7'($urandom), 8'($urandom), 8'(n));
				while (de_on) begin
					n = $urandom_range(19, 0);
					if (n == 0)
						put_random(OP_LOAD_TX);
					else if (n == 1)
						put_random(OP_START_TX);
					else
						put_random(OP_TX_DONE);
				end
			end else begin
				repeat (5)
					put_random(3'($urandom_range(7, 0)));
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_idle_ticks(8'd2);
		foreach (DIRECTED_ROWS[i])
			put_beat(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].data,
				DIRECTED_ROWS[i].len, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);

		run_phase(8'd255, 0, 0, 350, 1'b0);
		run_phase(8'd1, 71, 0, 250, 1'b0);
		run_phase(8'd0, 0, 71, 200, 1'b0);
		run_phase(8'd7, 34, 34, 300, 1'b0);
		run_phase(8'd128, 0, 0, 250, 1'b1);
		run_phase(8'd20, 0, 0, 200, 1'b0);

		wait_drained();
		if (fail_count == 0 && pending_status.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
